/* src/npcs_pkg.sv */
// Shared types and constants for the nearest palette color search core.
// Used by npcs_ctrl, npcs_dp and nearest_palette_color_search_core; no dependencies.
`default_nettype none

package npcs_pkg;

    localparam int unsigned DEFAULT_ENTRIES = 256;

    // operation field codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // RGB565 field layout
    localparam logic [15:0] RED_MASK    = 16'hF800;
    localparam logic [15:0] GREEN_MASK  = 16'h07E0;
    localparam logic [15:0] BLUE_MASK   = 16'h001F;
    localparam int unsigned RED_SHIFT   = 11;
    localparam int unsigned GREEN_SHIFT = 5;

    // sum of three 16-bit squares fits in 18 bits
    localparam int unsigned DIST_W = 18;

    typedef struct packed {
        logic load;   // write one palette entry from the input beat
        logic start;  // capture query color, reset scan address and best
        logic issue;  // read the entry at the scan address, advance
        logic emit;   // move the best index into the output register
    } npcs_cmd_t;

    typedef struct packed {
        logic addr_last;  // scan address points at the last entry
        logic busy;       // compare pipeline still holds entries
        logic out_free;   // output register can take a new beat
    } npcs_status_t;

endpackage

`default_nettype wire

/* src/nearest_palette_color_search_core.sv */
// Top level of the nearest palette color search core.
// Instantiates npcs_ctrl and npcs_dp; depends on npcs_pkg.
`default_nettype none

// Keeps a palette of PALETTE_ENTRIES RGB565 colors, all zero after reset. A load
// beat (operation 0) packs red, green and blue into entry entry_index and returns
// nothing; an index at or beyond PALETTE_ENTRIES is dropped. A query beat
// (operation 1) returns the index whose raw 5/6/5 fields have the smallest sum
// of squared differences to the 8-bit query color, lowest index on ties. The
// palette memory has one read port and is walked one entry per cycle into
// three pipeline stages, and in_stall stays high from acceptance until the
// result moves into the output register, longer while an earlier result still
// waits there; a load is taken every cycle while no query is in progress. The
// result sits in an output register, so a stalled result does not keep loads
// or the next query's scan from running. No clearing pass is needed after reset.
module nearest_palette_color_search_core
#(
    parameter int unsigned PALETTE_ENTRIES = npcs_pkg::DEFAULT_ENTRIES
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       operation,
    input  wire logic [7:0] entry_index,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      best_index
);

    import npcs_pkg::*;

    npcs_cmd_t    cmd;
    npcs_status_t status;

    npcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    npcs_dp
    #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_index  (best_index)
    );

endmodule

`default_nettype wire

/* src/npcs_ctrl.sv */
// Controller state machine for the nearest palette color search core.
// Depends on npcs_pkg for command/status structs and operation codes.
`default_nettype none

module npcs_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  operation,
    input  wire npcs_pkg::npcs_status_t status,
    output npcs_pkg::npcs_cmd_t         cmd
);

    import npcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd.load  = (state_reg == ST_IDLE) && in_valid && (operation == OP_LOAD);
        cmd.start = (state_reg == ST_IDLE) && in_valid && (operation == OP_QUERY);
        cmd.issue = (state_reg == ST_SCAN);
        cmd.emit  = (state_reg == ST_DRAIN) && !status.busy && status.out_free;
        in_stall  = (state_reg != ST_IDLE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.addr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // hold until the last compare lands and the output slot frees
                if (cmd.emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/npcs_dp.sv */
// Datapath for the nearest palette color search core: palette memory,
// scan address, squared-distance pipeline, running minimum and output register.
// Depends on npcs_pkg.
`default_nettype none

module npcs_dp
#(
    parameter int unsigned PALETTE_ENTRIES = npcs_pkg::DEFAULT_ENTRIES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire npcs_pkg::npcs_cmd_t    cmd,
    output npcs_pkg::npcs_status_t      status,
    input  wire logic [7:0]            entry_index,
    input  wire logic [7:0]            red,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            blue,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 best_index
);

    import npcs_pkg::*;

    localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

    function automatic logic [15:0] sq_abs_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    // palette storage; entries never written read as zero through live_reg
    logic [15:0]                mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] live_reg;

    logic            load_hit;
    logic [AW-1:0]   waddr;
    logic [15:0]     wdata;

    logic [AW-1:0]   addr_reg;
    logic [7:0]      qr_reg;
    logic [7:0]      qg_reg;
    logic [7:0]      qb_reg;

    // stage 1: memory read
    logic            s1_valid_reg;
    logic [AW-1:0]   s1_idx_reg;
    logic [15:0]     rd_word_reg;
    logic            rd_live_reg;
    logic [15:0]     entry_word;
    logic [7:0]      ent_r;
    logic [7:0]      ent_g;
    logic [7:0]      ent_b;

    // stage 2: squared differences
    logic            s2_valid_reg;
    logic [AW-1:0]   s2_idx_reg;
    logic [15:0]     sq_r_reg;
    logic [15:0]     sq_g_reg;
    logic [15:0]     sq_b_reg;

    // stage 3: running minimum
    logic [DIST_W-1:0] dist_sum;
    logic              take_new;
    logic              have_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [AW-1:0]     best_idx_reg;

    logic              out_valid_reg;
    logic [7:0]        out_index_reg;

    assign load_hit = cmd.load && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
    assign waddr    = entry_index[AW-1:0];
    assign wdata    = {red[7:3], green[7:2], blue[7:3]};

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.issue)
        begin
            rd_word_reg <= mem[addr_reg];
            rd_live_reg <= live_reg[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (load_hit)
        begin
            live_reg[waddr] <= 1'b1;
        end
    end

    assign entry_word = rd_live_reg ? rd_word_reg : 16'h0000;
    assign ent_r = 8'((entry_word & RED_MASK) >> RED_SHIFT);
    assign ent_g = 8'((entry_word & GREEN_MASK) >> GREEN_SHIFT);
    assign ent_b = 8'(entry_word & BLUE_MASK);

    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    // strict less-than keeps the lowest index on ties
    assign take_new = s2_valid_reg && (!have_reg || (dist_sum < best_dist_reg));

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qr_reg <= red;
            qg_reg <= green;
            qb_reg <= blue;
        end
        s1_idx_reg <= addr_reg;
        s2_idx_reg <= s1_idx_reg;
        sq_r_reg   <= sq_abs_diff(qr_reg, ent_r);
        sq_g_reg   <= sq_abs_diff(qg_reg, ent_g);
        sq_b_reg   <= sq_abs_diff(qb_reg, ent_b);
        if (take_new)
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= s2_idx_reg;
        end
        if (cmd.emit)
        begin
            out_index_reg <= 8'(best_idx_reg);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.start)
            begin
                have_reg <= 1'b0;
            end
            else if (take_new)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.addr_last = (addr_reg == AW'(PALETTE_ENTRIES - 1));
        status.busy      = s1_valid_reg | s2_valid_reg;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign best_index = out_index_reg;

`ifndef SYNTH
    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !s1_valid_reg && !s2_valid_reg)
        else $error("result emitted while compare pipeline still busy");

    a_no_load_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !cmd.load && !cmd.start)
        else $error("load or new query during palette scan");

    a_start_clears_addr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (addr_reg == '0) && !have_reg)
        else $error("scan did not restart at entry zero");

    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("compare stage valid without a read the cycle before");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for nearest_palette_color_search_core.
// Mirrors the palette, predicts every query and checks each result beat; depends on npcs_pkg.
module testbench;
    import npcs_pkg::*;

    localparam int unsigned ENTRIES      = DEFAULT_ENTRIES;
    localparam int unsigned DRAIN_CYCLES = ENTRIES + 16;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       operation   = OP_LOAD;
    logic [7:0] entry_index = '0;
    logic [7:0] red         = '0;
    logic [7:0] green       = '0;
    logic [7:0] blue        = '0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] best_index;

    logic [15:0] palette_shadow [ENTRIES];
    logic [7:0]  pending_best [$];
    logic [7:0]  want_index;
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    nearest_palette_color_search_core #(
        .PALETTE_ENTRIES (ENTRIES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_index  (best_index)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("FAIL nearest_palette_color_search_core");
        $finish;
    end

    // Walk the shadow palette; strict less-than keeps the lowest index on ties.
    function automatic logic [7:0] nearest_entry(input logic [7:0] r, g, b);
        int unsigned best_dist;
        int unsigned sum_sq;
        int          dr, dg, db;
        logic [7:0]  best;
        best      = '0;
        best_dist = 32'hFFFF_FFFF;
        for (int i = 0; i < ENTRIES; i++)
        begin
            dr     = int'(r) - int'((palette_shadow[i] & RED_MASK) >> RED_SHIFT);
            dg     = int'(g) - int'((palette_shadow[i] & GREEN_MASK) >> GREEN_SHIFT);
            db     = int'(b) - int'(palette_shadow[i] & BLUE_MASK);
            sum_sq = dr * dr + dg * dg + db * db;
            if (sum_sq < best_dist)
            begin
                best_dist = sum_sq;
                best      = i[7:0];
            end
        end
        return best;
    endfunction

    // Offer one beat, wait for it to be taken, then update the shadow palette
    // or queue the expected index.
    task automatic send_beat(input logic op, input logic [7:0] idx, r, g, b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_LOAD)
        begin
            if (idx < ENTRIES)
                palette_shadow[idx] = {r[7:3], g[7:2], b[7:3]};
        end
        else
            pending_best.push_back(nearest_entry(r, g, b));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_best.size() == 0)
            begin
                mismatches++;
                $display("%0t: best_index expected none, got %0d", $time, best_index);
            end
            else
            begin
                want_index = pending_best.pop_front();
                if (best_index !== want_index)
                begin
                    mismatches++;
                    $display("%0t: best_index expected %0d, got %0d",
                             $time, want_index, best_index);
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every entry is zero after reset, so any query lands on entry 0.
    task automatic test_cleared_palette();
        send_beat(OP_QUERY, 8'hA5, 8'd0, 8'd0, 8'd0);
        send_beat(OP_QUERY, 8'h5A, 8'd255, 8'd255, 8'd255);
        send_beat(OP_QUERY, 8'hFF, 8'd31, 8'd63, 8'd31);
    endtask

    task automatic test_field_extremes();
        send_beat(OP_LOAD, 8'd255, 8'd255, 8'd255, 8'd255);
        send_beat(OP_LOAD, 8'd1, 8'd255, 8'd0, 8'd0);
        send_beat(OP_LOAD, 8'd2, 8'd0, 8'd255, 8'd0);
        send_beat(OP_LOAD, 8'd3, 8'd0, 8'd0, 8'd255);
        // low bits alone pack to zero
        send_beat(OP_LOAD, 8'd4, 8'd7, 8'd3, 8'd7);
        send_beat(OP_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
        send_beat(OP_QUERY, 8'd0, 8'd31, 8'd0, 8'd0);
        send_beat(OP_QUERY, 8'd0, 8'd0, 8'd63, 8'd0);
        send_beat(OP_QUERY, 8'd0, 8'd0, 8'd0, 8'd31);
        send_beat(OP_QUERY, 8'd255, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_lowest_index_on_tie();
        send_beat(OP_LOAD, 8'd10, 8'd100, 8'd100, 8'd100);
        send_beat(OP_LOAD, 8'd20, 8'd100, 8'd100, 8'd100);
        send_beat(OP_QUERY, 8'd0, 8'd12, 8'd25, 8'd12);
        // red fields 10 and 12 sit equally far from 11
        send_beat(OP_LOAD, 8'd30, 8'd80, 8'd0, 8'd0);
        send_beat(OP_LOAD, 8'd31, 8'd96, 8'd0, 8'd0);
        send_beat(OP_QUERY, 8'd0, 8'd11, 8'd0, 8'd0);
        send_beat(OP_LOAD, 8'd40, 8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_overwrite();
        send_beat(OP_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
        send_beat(OP_LOAD, 8'd30, 8'd0, 8'd0, 8'd0);
        send_beat(OP_LOAD, 8'd40, 8'd0, 8'd0, 8'd0);
        send_beat(OP_QUERY, 8'd0, 8'd11, 8'd0, 8'd0);
        send_beat(OP_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_random_traffic(input int count);
        int unsigned kind;
        logic [7:0]  idx, r, g, b;
        logic [15:0] w;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            idx  = 8'($urandom);
            r    = 8'($urandom);
            g    = 8'($urandom);
            b    = 8'($urandom);
            w    = palette_shadow[$urandom_range(ENTRIES - 1)];
            if (kind < 70)
            begin
                // copy a stored color now and then to build ties
                if (kind < 8)
                begin
                    r = {w[15:11], 3'($urandom_range(7))};
                    g = {w[10:5], 2'($urandom_range(3))};
                    b = {w[4:0], 3'($urandom_range(7))};
                end
                send_beat(OP_LOAD, idx, r, g, b);
            end
            else
            begin
                if (kind < 80)
                begin
                    r = 8'((w & RED_MASK) >> RED_SHIFT);
                    g = 8'((w & GREEN_MASK) >> GREEN_SHIFT);
                    b = 8'(w & BLUE_MASK);
                end
                else if (kind < 90)
                begin
                    // stay near the raw field ranges where the search is close
                    r = 8'($urandom_range(40));
                    g = 8'($urandom_range(72));
                    b = 8'($urandom_range(40));
                end
                send_beat(OP_QUERY, idx, r, g, b);
            end
        end
    endtask

    initial
    begin
        foreach (palette_shadow[i])
            palette_shadow[i] = '0;
        send_idle_pct  = 15;
        recv_stall_pct = 73;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_palette();
        test_field_extremes();
        test_lowest_index_on_tie();
        test_overwrite();
        test_random_traffic(610);

        send_idle_pct  = 73;
        recv_stall_pct = 15;
        test_random_traffic(610);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(610);

        in_valid <= 1'b0;
        while (pending_best.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS nearest_palette_color_search_core");
        else
            $display("FAIL nearest_palette_color_search_core");
        $finish;
    end

endmodule
